/* rtl/pmrt_pkg.sv */
`timescale 1ns / 1ps

package pmrt_pkg;

	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int TAB_W    = FRAC_W + 1;
	localparam int TRIG_W   = FRAC_W + 2;
	localparam int PROD_W   = COORD_W + TRIG_W;
	localparam int ROT_W    = PROD_W + 1;
	localparam int NUM_RES  = 90;
	localparam int RES_W    = $clog2(NUM_RES);
	localparam int ANG_W    = 9;
	localparam int IDX_W    = 2;
	localparam int DATA_W   = 32;

	localparam logic [IDX_W-1:0] REG_MIRROR   = 2'd0;
	localparam logic [IDX_W-1:0] REG_ANGLE    = 2'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 2'd2;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 2'd3;

	localparam logic [ANG_W-1:0] DEG_QUAD = 9'd90;
	localparam logic [ANG_W-1:0] DEG_HALF = 9'd180;
	localparam logic [ANG_W-1:0] DEG_3Q   = 9'd270;
	localparam logic [ANG_W-1:0] DEG_FULL = 9'd360;

	localparam logic [63:0] DEG_Q30 = 64'd18740330;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(64'd1 << FRAC_W);

	typedef logic [NUM_RES-1:0][TAB_W-1:0] trig_tab_t;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] corner0_x;
		logic signed [31:0] corner0_y;
		logic signed [31:0] corner1_x;
		logic signed [31:0] corner1_y;
		logic signed [31:0] corner2_x;
		logic signed [31:0] corner2_y;
		logic signed [31:0] corner3_x;
		logic signed [31:0] corner3_y;
	} pmrt_item_t;

	typedef struct packed {
		logic signed [31:0] board0_x;
		logic signed [31:0] board0_y;
		logic signed [31:0] board1_x;
		logic signed [31:0] board1_y;
		logic signed [31:0] board2_x;
		logic signed [31:0] board2_y;
		logic signed [31:0] board3_x;
		logic signed [31:0] board3_y;
	} pmrt_result_t;

	// stage load enables for the corner datapath
	typedef struct packed {
		logic s2;
		logic s3;
	} pmrt_adv_t;

	// Q30 Taylor series per residue degree, rounded to the trig fraction width.
	// Elaboration only.
	function automatic trig_tab_t build_tab(input logic want_cos);
		trig_tab_t          tab;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        ts;
		logic [63:0]        tc;
		logic [63:0]        v;
		logic signed [63:0] ss;
		logic signed [63:0] cs;
		tab = '0;
		for (int r = 0; r < NUM_RES; r++) begin
			x  = 64'(r) * DEG_Q30;
			x2 = (x * x) >> 30;
			ss = signed'(x);
			cs = signed'(ONE_Q30);
			ts = x;
			tc = ONE_Q30;
			for (int k = 1; k <= 8; k++) begin
				ts = (ts * x2) >> 30;
				tc = (tc * x2) >> 30;
				case (k)
					1: begin
						ts = ts / 6;
						tc = tc / 2;
					end
					2: begin
						ts = ts / 20;
						tc = tc / 12;
					end
					3: begin
						ts = ts / 42;
						tc = tc / 30;
					end
					4: begin
						ts = ts / 72;
						tc = tc / 56;
					end
					5: begin
						ts = ts / 110;
						tc = tc / 90;
					end
					6: begin
						ts = ts / 156;
						tc = tc / 132;
					end
					7: begin
						ts = ts / 210;
						tc = tc / 182;
					end
					default: begin
						ts = ts / 272;
						tc = tc / 240;
					end
				endcase
				if ((k % 2) == 1) begin
					ss = ss - signed'(ts);
					cs = cs - signed'(tc);
				end else begin
					ss = ss + signed'(ts);
					cs = cs + signed'(tc);
				end
			end
			if (ss < 0) ss = '0;
			if (cs < 0) cs = '0;
			v = want_cos ? unsigned'(cs) : unsigned'(ss);
			if (v > ONE_Q30) v = ONE_Q30;
			v = (v + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W);
			tab[r] = v[TAB_W-1:0];
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_tab(1'b0);
	localparam trig_tab_t COS_TAB = build_tab(1'b1);

endpackage

/* rtl/pad_mirror_rotate_translate_core.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle while result_ready keeps the output moving; the
// stages, in order, are a capture register, the multiplier bank, the
// rotate/truncate/offset adders and the centroid output register.
// Reset: asynchronous, active low; clears all stage valids and the registers
// (mirror off, angle 0 giving sine 0 and cosine 1, origin 0).
module pad_mirror_rotate_translate_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pmrt_pkg::IDX_W-1:0]     wr_index,
	input  logic [pmrt_pkg::DATA_W-1:0]    wr_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  pmrt_pkg::pmrt_item_t           item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output pmrt_pkg::pmrt_result_t         result
);

	localparam int CW = pmrt_pkg::COORD_W;

	logic                               mirror_q;
	logic signed [CW-1:0]               origin_x_q;
	logic signed [CW-1:0]               origin_y_q;
	logic signed [pmrt_pkg::TRIG_W-1:0] sin_q;
	logic signed [pmrt_pkg::TRIG_W-1:0] cos_q;

	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    valid_s4;
	logic                    rdy1;
	logic                    rdy2;
	logic                    rdy3;
	logic                    rdy4;
	pmrt_pkg::pmrt_item_t    item_s1;
	logic                    op_s2;
	logic                    op_s3;
	pmrt_pkg::pmrt_result_t  result_s4;
	pmrt_pkg::pmrt_adv_t     adv;

	logic signed [CW-1:0] cx [4];
	logic signed [CW-1:0] cy [4];
	logic signed [CW-1:0] px_s3 [4];
	logic signed [CW-1:0] py_s3 [4];
	logic signed [CW-1:0] sum_x;
	logic signed [CW-1:0] sum_y;
	logic signed [CW-1:0] cen_x;
	logic signed [CW-1:0] cen_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q   <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				pmrt_pkg::REG_MIRROR:   mirror_q   <= wr_data[0];
				pmrt_pkg::REG_ORIGIN_X: origin_x_q <= wr_data[CW-1:0];
				pmrt_pkg::REG_ORIGIN_Y: origin_y_q <= wr_data[CW-1:0];
				default: ;
			endcase
		end
	end

	pmrt_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (wr_en && (wr_index == pmrt_pkg::REG_ANGLE)),
		.angle  (wr_data[pmrt_pkg::ANG_W-1:0]),
		.sin_q  (sin_q),
		.cos_q  (cos_q)
	);

	// bubbles collapse: a stage loads when it is empty or its contents move on
	always_comb begin
		rdy4       = !valid_s4 || result_ready;
		rdy3       = !valid_s3 || rdy4;
		rdy2       = !valid_s2 || rdy3;
		rdy1       = !valid_s1 || rdy2;
		item_ready = rdy1;
		adv.s2     = rdy2;
		adv.s3     = rdy3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= item_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) item_s1 <= item;
		if (rdy2) op_s2 <= item_s1.operation;
		if (rdy3) op_s3 <= op_s2;
	end

	always_comb begin
		cx[0] = item_s1.corner0_x;
		cy[0] = item_s1.corner0_y;
		cx[1] = item_s1.corner1_x;
		cy[1] = item_s1.corner1_y;
		cx[2] = item_s1.corner2_x;
		cy[2] = item_s1.corner2_y;
		cx[3] = item_s1.corner3_x;
		cy[3] = item_s1.corner3_y;
	end

	for (genvar i = 0; i < 4; i++) begin : g_corner
		pmrt_corner u_corner (
			.clk    (clk),
			.adv    (adv),
			.mirror (mirror_q),
			.x      (cx[i]),
			.y      (cy[i]),
			.sin_v  (sin_q),
			.cos_v  (cos_q),
			.ox     (origin_x_q),
			.oy     (origin_y_q),
			.px_s3  (px_s3[i]),
			.py_s3  (py_s3[i])
		);
	end

	// centroid: wrapped sum over four, toward zero
	always_comb begin
		sum_x = px_s3[0] + px_s3[1] + px_s3[2] + px_s3[3];
		sum_y = py_s3[0] + py_s3[1] + py_s3[2] + py_s3[3];
		cen_x = (sum_x + (sum_x[CW-1] ? CW'(3) : CW'(0))) >>> 2;
		cen_y = (sum_y + (sum_y[CW-1] ? CW'(3) : CW'(0))) >>> 2;
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			result_s4.board0_x <= op_s3 ? cen_x : px_s3[0];
			result_s4.board0_y <= op_s3 ? cen_y : py_s3[0];
			result_s4.board1_x <= px_s3[1];
			result_s4.board1_y <= py_s3[1];
			result_s4.board2_x <= px_s3[2];
			result_s4.board2_y <= py_s3[2];
			result_s4.board3_x <= px_s3[3];
			result_s4.board3_y <= py_s3[3];
		end
	end

	assign result_valid = valid_s4;
	assign result       = result_s4;

endmodule

/* rtl/pmrt_trig.sv */
`timescale 1ns / 1ps

module pmrt_trig (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [pmrt_pkg::ANG_W-1:0]           angle,
	output logic signed [pmrt_pkg::TRIG_W-1:0]   sin_q,
	output logic signed [pmrt_pkg::TRIG_W-1:0]   cos_q
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic [pmrt_pkg::ANG_W-1:0]         deg;
	logic [pmrt_pkg::ANG_W-1:0]         res_full;
	logic [pmrt_pkg::RES_W-1:0]         res;
	logic [1:0]                         quad;
	logic signed [pmrt_pkg::TRIG_W-1:0] s0;
	logic signed [pmrt_pkg::TRIG_W-1:0] c0;
	logic signed [pmrt_pkg::TRIG_W-1:0] sin_d;
	logic signed [pmrt_pkg::TRIG_W-1:0] cos_d;

	always_comb begin
		deg = (angle >= pmrt_pkg::DEG_FULL) ? angle - pmrt_pkg::DEG_FULL : angle;
		if (deg >= pmrt_pkg::DEG_3Q) begin
			quad     = QUAD_3;
			res_full = deg - pmrt_pkg::DEG_3Q;
		end else if (deg >= pmrt_pkg::DEG_HALF) begin
			quad     = QUAD_2;
			res_full = deg - pmrt_pkg::DEG_HALF;
		end else if (deg >= pmrt_pkg::DEG_QUAD) begin
			quad     = QUAD_1;
			res_full = deg - pmrt_pkg::DEG_QUAD;
		end else begin
			quad     = QUAD_0;
			res_full = deg;
		end
		res = res_full[pmrt_pkg::RES_W-1:0];
		s0  = signed'({1'b0, pmrt_pkg::SIN_TAB[res]});
		c0  = signed'({1'b0, pmrt_pkg::COS_TAB[res]});
		case (quad)
			QUAD_0: begin
				sin_d = s0;
				cos_d = c0;
			end
			QUAD_1: begin
				sin_d = c0;
				cos_d = -s0;
			end
			QUAD_2: begin
				sin_d = -s0;
				cos_d = -c0;
			end
			default: begin
				sin_d = -c0;
				cos_d = s0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_q <= '0;
			cos_q <= pmrt_pkg::TRIG_ONE;
		end else if (load) begin
			sin_q <= sin_d;
			cos_q <= cos_d;
		end
	end

endmodule

/* rtl/pmrt_corner.sv */
`timescale 1ns / 1ps

module pmrt_corner (
	input  logic                                 clk,
	input  pmrt_pkg::pmrt_adv_t                  adv,
	input  logic                                 mirror,
	input  logic signed [pmrt_pkg::COORD_W-1:0]  x,
	input  logic signed [pmrt_pkg::COORD_W-1:0]  y,
	input  logic signed [pmrt_pkg::TRIG_W-1:0]   sin_v,
	input  logic signed [pmrt_pkg::TRIG_W-1:0]   cos_v,
	input  logic signed [pmrt_pkg::COORD_W-1:0]  ox,
	input  logic signed [pmrt_pkg::COORD_W-1:0]  oy,
	output logic signed [pmrt_pkg::COORD_W-1:0]  px_s3,
	output logic signed [pmrt_pkg::COORD_W-1:0]  py_s3
);

	localparam int PW = pmrt_pkg::PROD_W;
	localparam int RW = pmrt_pkg::ROT_W;
	localparam logic signed [RW-1:0] TRUNC_BIAS = RW'((64'd1 << pmrt_pkg::FRAC_W) - 64'd1);

	logic signed [pmrt_pkg::COORD_W-1:0] xm;
	logic signed [PW-1:0]                xm_e;
	logic signed [PW-1:0]                y_e;
	logic signed [PW-1:0]                sin_e;
	logic signed [PW-1:0]                cos_e;
	logic signed [PW-1:0]                xc_s2;
	logic signed [PW-1:0]                ys_s2;
	logic signed [PW-1:0]                xs_s2;
	logic signed [PW-1:0]                yc_s2;
	logic signed [RW-1:0]                rx;
	logic signed [RW-1:0]                ry;
	logic signed [RW-1:0]                tx;
	logic signed [RW-1:0]                ty;

	always_comb begin
		xm    = mirror ? -x : x;
		xm_e  = PW'(xm);
		y_e   = PW'(y);
		sin_e = PW'(sin_v);
		cos_e = PW'(cos_v);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			xc_s2 <= xm_e * cos_e;
			ys_s2 <= y_e * sin_e;
			xs_s2 <= xm_e * sin_e;
			yc_s2 <= y_e * cos_e;
		end
	end

	// divide by 2^F rounding toward zero
	always_comb begin
		rx = RW'(xc_s2) - RW'(ys_s2);
		ry = RW'(xs_s2) + RW'(yc_s2);
		tx = (rx + (rx[RW-1] ? TRUNC_BIAS : '0)) >>> pmrt_pkg::FRAC_W;
		ty = (ry + (ry[RW-1] ? TRUNC_BIAS : '0)) >>> pmrt_pkg::FRAC_W;
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			px_s3 <= tx[pmrt_pkg::COORD_W-1:0] + ox;
			py_s3 <= ty[pmrt_pkg::COORD_W-1:0] + oy;
		end
	end

endmodule

/* rtl/pmrt_checker.sv */
`timescale 1ns / 1ps

module pmrt_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic                    item_ready,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  pmrt_pkg::pmrt_result_t  result
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// free output means the front end takes requests
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> item_ready)
		else $error("request refused with output free");

	// unstalled request comes out as a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready ##1 result_ready ##1 result_ready ##1 result_ready
		|=> result_valid)
		else $error("result missing after unstalled request");

	// a fresh result always traces back to an accepted request
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready, 4))
		else $error("result without matching request");

endmodule

bind pad_mirror_rotate_translate_core pmrt_checker u_pmrt_checker (.*);

/* bench/pad_mirror_rotate_translate_core_test.sv */
`timescale 1ns / 1ps

module pad_mirror_rotate_translate_core_test;

	localparam logic OP_PLACE    = 1'b0;
	localparam logic OP_CENTROID = 1'b1;

	localparam int          TRIG_FRAC      = 16;
	localparam logic [63:0] Q30_ONE        = 64'd1 << 30;
	localparam logic [63:0] Q30_PER_DEGREE = 64'd18740330;
	localparam int          DEGREES_QUAD   = 90;
	localparam int          DEGREES_TURN   = 360;
	localparam int          COORD_MAX      = 32'h7fffffff;
	localparam int          COORD_MIN      = 32'h80000000;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 6;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            wr_en        = 1'b0;
	logic [pmrt_pkg::IDX_W-1:0]      wr_index     = '0;
	logic [pmrt_pkg::DATA_W-1:0]     wr_data      = '0;
	logic                            item_valid   = 1'b0;
	logic                            item_ready;
	pmrt_pkg::pmrt_item_t            item         = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	pmrt_pkg::pmrt_result_t          result;

	// placement registers as last written
	logic                            cfg_mirror   = 1'b0;
	logic [pmrt_pkg::ANG_W-1:0]      cfg_angle    = '0;
	logic signed [31:0]              cfg_origin_x = '0;
	logic signed [31:0]              cfg_origin_y = '0;

	pmrt_pkg::pmrt_item_t            pads_to_send[$];
	pmrt_pkg::pmrt_result_t          expected_boards[$];
	pmrt_pkg::pmrt_result_t          board_want;
	int                              send_idle_pct = 0;
	int                              recv_idle_pct = 0;
	bit                              hold_req      = 1'b0;
	int                              hold_count    = 0;
	int                              mismatches    = 0;

	pad_mirror_rotate_translate_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	function automatic longint wrap32(longint v);
		logic signed [31:0] t;
		t = v[31:0];
		return t;
	endfunction

	// Taylor series in Q30 for a residue angle of 0..89 degrees, rounded to Q16
	function automatic void series_sin_cos(int r, output longint s, output longint c);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] vs;
		logic [63:0] vc;
		longint      ss;
		longint      cs;
		x  = 64'(r) * Q30_PER_DEGREE;
		x2 = (x * x) >> 30;
		ss = longint'(x);
		cs = longint'(Q30_ONE);
		ts = x;
		tc = Q30_ONE;
		for (int k = 1; k <= 8; k++) begin
			ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				ss -= longint'(ts);
				cs -= longint'(tc);
			end else begin
				ss += longint'(ts);
				cs += longint'(tc);
			end
		end
		vs = (ss < 0) ? 64'd0 : 64'(ss);
		vc = (cs < 0) ? 64'd0 : 64'(cs);
		if (vs > Q30_ONE) vs = Q30_ONE;
		if (vc > Q30_ONE) vc = Q30_ONE;
		s = longint'((vs + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
		c = longint'((vc + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
	endfunction

	function automatic pmrt_pkg::pmrt_result_t place_pad(pmrt_pkg::pmrt_item_t pad);
		pmrt_pkg::pmrt_result_t board;
		longint                 cx[4];
		longint                 cy[4];
		longint                 px[4];
		longint                 py[4];
		longint                 s;
		longint                 c;
		longint                 s0;
		longint                 c0;
		longint                 x;
		longint                 y;
		longint                 nx;
		longint                 ny;
		int                     deg;
		cx[0] = pad.corner0_x;
		cy[0] = pad.corner0_y;
		cx[1] = pad.corner1_x;
		cy[1] = pad.corner1_y;
		cx[2] = pad.corner2_x;
		cy[2] = pad.corner2_y;
		cx[3] = pad.corner3_x;
		cy[3] = pad.corner3_y;
		deg = int'(cfg_angle) % DEGREES_TURN;
		s = 0;
		c = longint'(1) << TRIG_FRAC;
		if (deg != 0) begin
			series_sin_cos(deg % DEGREES_QUAD, s0, c0);
			case (deg / DEGREES_QUAD)
				0: begin
					s = s0;
					c = c0;
				end
				1: begin
					s = c0;
					c = -s0;
				end
				2: begin
					s = -s0;
					c = -c0;
				end
				default: begin
					s = -c0;
					c = s0;
				end
			endcase
		end
		for (int i = 0; i < 4; i++) begin
			x = cx[i];
			y = cy[i];
			if (cfg_mirror) x = wrap32(-x);
			if (deg != 0) begin
				nx = (x * c - y * s) / (longint'(1) << TRIG_FRAC);
				ny = (x * s + y * c) / (longint'(1) << TRIG_FRAC);
				x  = wrap32(nx);
				y  = wrap32(ny);
			end
			px[i] = wrap32(x + longint'(cfg_origin_x));
			py[i] = wrap32(y + longint'(cfg_origin_y));
		end
		if (pad.operation == OP_CENTROID) begin
			px[0] = wrap32(px[0] + px[1] + px[2] + px[3]) / 4;
			py[0] = wrap32(py[0] + py[1] + py[2] + py[3]) / 4;
		end
		board.board0_x = px[0][31:0];
		board.board0_y = py[0][31:0];
		board.board1_x = px[1][31:0];
		board.board1_y = py[1][31:0];
		board.board2_x = px[2][31:0];
		board.board2_y = py[2][31:0];
		board.board3_x = px[3][31:0];
		board.board3_y = py[3][31:0];
		return board;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 15))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return -1;
			3: return 0;
			4, 5, 6, 7: return $urandom();
			default: return int'($urandom_range(0, 2097152)) - 1048576;
		endcase
	endfunction

	function automatic pmrt_pkg::pmrt_item_t random_pad();
		pmrt_pkg::pmrt_item_t pad;
		int                   mx;
		int                   my;
		int                   hw;
		int                   hh;
		pad.operation = $urandom_range(0, 1) ? OP_CENTROID : OP_PLACE;
		if ($urandom_range(0, 1)) begin
			// rectangular pad around a centre
			mx = int'($urandom_range(0, 2000000)) - 1000000;
			my = int'($urandom_range(0, 2000000)) - 1000000;
			hw = $urandom_range(1, 50000);
			hh = $urandom_range(1, 50000);
			pad.corner0_x = mx - hw;
			pad.corner0_y = my - hh;
			pad.corner1_x = mx + hw;
			pad.corner1_y = my - hh;
			pad.corner2_x = mx + hw;
			pad.corner2_y = my + hh;
			pad.corner3_x = mx - hw;
			pad.corner3_y = my + hh;
		end else begin
			pad.corner0_x = rand_coord();
			pad.corner0_y = rand_coord();
			pad.corner1_x = rand_coord();
			pad.corner1_y = rand_coord();
			pad.corner2_x = rand_coord();
			pad.corner2_y = rand_coord();
			pad.corner3_x = rand_coord();
			pad.corner3_y = rand_coord();
		end
		return pad;
	endfunction

	task automatic push_pad(logic op, int x0, int y0, int x1, int y1,
			int x2, int y2, int x3, int y3);
		pmrt_pkg::pmrt_item_t pad;
		pad.operation = op;
		pad.corner0_x = x0;
		pad.corner0_y = y0;
		pad.corner1_x = x1;
		pad.corner1_y = y1;
		pad.corner2_x = x2;
		pad.corner2_y = y2;
		pad.corner3_x = x3;
		pad.corner3_y = y3;
		pads_to_send.push_back(pad);
	endtask

	task automatic write_reg(logic [pmrt_pkg::IDX_W-1:0] idx,
			logic [pmrt_pkg::DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			pmrt_pkg::REG_MIRROR:   cfg_mirror   = data[0];
			pmrt_pkg::REG_ANGLE:    cfg_angle    = data[pmrt_pkg::ANG_W-1:0];
			pmrt_pkg::REG_ORIGIN_X: cfg_origin_x = data;
			pmrt_pkg::REG_ORIGIN_Y: cfg_origin_y = data;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// upper bits of the mirror and angle words are junk the block must drop
	task automatic set_placement(logic m, int ang, int ox, int oy);
		logic [pmrt_pkg::DATA_W-1:0] d;
		d = $urandom();
		d[0] = m;
		write_reg(pmrt_pkg::REG_MIRROR, d);
		d = $urandom();
		d[pmrt_pkg::ANG_W-1:0] = ang[pmrt_pkg::ANG_W-1:0];
		write_reg(pmrt_pkg::REG_ANGLE, d);
		write_reg(pmrt_pkg::REG_ORIGIN_X, ox);
		write_reg(pmrt_pkg::REG_ORIGIN_Y, oy);
	endtask

	task automatic random_placement();
		int ang;
		case ($urandom_range(0, 5))
			0: ang = DEGREES_QUAD * $urandom_range(0, 3);
			1: ang = $urandom_range(DEGREES_TURN, 511);
			2: ang = $urandom_range(0, 1) ? DEGREES_TURN - 1 : 1;
			default: ang = $urandom_range(0, DEGREES_TURN - 1);
		endcase
		set_placement(1'($urandom_range(0, 1)), ang, rand_coord(), rand_coord());
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pads_to_send.size() != 0 || item_valid || expected_boards.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic compare_coord(string field, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (item_valid && item_ready)
			expected_boards.push_back(place_pad(item));
		if (!item_valid || item_ready) begin
			if (arst_n && pads_to_send.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				item       <= pads_to_send.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (expected_boards.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				board_want = expected_boards.pop_front();
				compare_coord("board0_x", board_want.board0_x, result.board0_x);
				compare_coord("board0_y", board_want.board0_y, result.board0_y);
				compare_coord("board1_x", board_want.board1_x, result.board1_x);
				compare_coord("board1_y", board_want.board1_y, result.board1_y);
				compare_coord("board2_x", board_want.board2_x, result.board2_x);
				compare_coord("board2_y", board_want.board2_y, result.board2_y);
				compare_coord("board3_x", board_want.board3_x, result.board3_x);
				compare_coord("board3_y", board_want.board3_y, result.board3_y);
			end
		end
		if (hold_req && hold_count < HOLD_CYCLES) begin
			hold_count++;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset placement, then extremes in both modes
		push_pad(OP_PLACE, 0, 0, 0, 0, 0, 0, 0, 0);
		push_pad(OP_PLACE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, -1, 1, 0, -1);
		push_pad(OP_CENTROID, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		push_pad(OP_CENTROID, COORD_MIN, -3, COORD_MIN, -2, COORD_MIN, 1, -1, 1);
		drain();

		// mirror wraps the most negative x; origin addition wraps
		set_placement(1'b1, 90, COORD_MAX, COORD_MIN);
		push_pad(OP_PLACE, COORD_MIN, 5, 7, COORD_MIN, COORD_MAX, -1, 1000, 2000);
		push_pad(OP_CENTROID, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 3, 3, -3, -3);
		drain();

		set_placement(1'b0, 45, -1, 1);
		push_pad(OP_PLACE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MIN, 12345, -6789);
		push_pad(OP_CENTROID, -500, -300, 500, -300, 500, 300, -500, 300);
		drain();

		set_placement(1'b1, 180, 1000, -1000);
		push_pad(OP_PLACE, COORD_MIN, COORD_MAX, 1, 2, -3, -4, 100, 200);
		drain();
		set_placement(1'b0, 270, 0, 0);
		push_pad(OP_CENTROID, 10, 20, 30, 40, -50, -60, 70, 80);
		drain();
		set_placement(1'b1, 359, 7, 7);
		push_pad(OP_PLACE, 65536, -65536, COORD_MAX, 0, 0, COORD_MIN, 3, -3);
		drain();
		// angles of a full turn or more fold back into range
		set_placement(1'b0, 360, 5, -5);
		push_pad(OP_PLACE, 1, 2, 3, 4, 5, 6, 7, 8);
		drain();
		set_placement(1'b0, 511, COORD_MIN, COORD_MAX);
		push_pad(OP_CENTROID, 100000, 0, 0, 100000, -100000, 0, 0, -100000);
		drain();
		set_placement(1'b1, 1, 0, 0);
		push_pad(OP_PLACE, 1000000, 1000000, -1, -1, COORD_MAX, COORD_MAX, 0, 0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 6; seg++) begin
				random_placement();
				if (phase == 2 && seg == 0)
					hold_req = 1'b1;
				repeat (72) pads_to_send.push_back(random_pad());
				drain();
			end
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/pmrt_pkg.sv
rtl/pmrt_trig.sv
rtl/pmrt_corner.sv
rtl/pad_mirror_rotate_translate_core.sv
rtl/pmrt_checker.sv
bench/pad_mirror_rotate_translate_core_test.sv
